// ===== sv/mrgs_pkg.sv =====
// Shared types and constants for the merge sorter.
package mrgs_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_MSET = 6'b000010,
    ST_MRD  = 6'b000100,
    ST_MCMP = 6'b001000,
    ST_ERD  = 6'b010000,
    ST_EOUT = 6'b100000
  } state_e;

endpackage

// ===== sv/mrgs_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module mrgs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== sv/merge_sorter_unit.sv =====
// Merge sorter top level: buffers a set of values, sorts it stably and streams it out.
//
//   channel  direction  tdata                 tlast           tuser
//   s_axis   in         [31:0] value          last of the set -
//   m_axis   out        [31:0] sorted_value   last of the set [0] dropped
//
// Loading takes one cycle per item; tready is high only while loading.
// The sort runs ceil(log2(n)) bottom-up merge passes through one shared compare unit,
// ping-ponging between two RAMs: each merge of two runs has a setup state (MSET), then a
// read state (MRD) and a compare/write state (MCMP) per element. Each result is emitted by
// a read state (ERD) then an output state (EOUT). tready stays low from the last item until
// the final result is taken; an output stall just holds the result. Reset empties the set.
module merge_sorter_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [mrgs_pkg::DATA_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [mrgs_pkg::DATA_W-1:0] m_axis_tdata,  // [31:0] sorted_value
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser   // [0] dropped
);

  import mrgs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = WW + 1;

  state_e state_q, state_d;

  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] n_q, n_d;
  logic [WW-1:0] w_q, w_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] e_q, e_d;
  logic          src_q, src_d;

  logic              in_acc, out_acc, has_room;
  logic              we_a, we_b;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] ra_a, rb_a, ra_b, rb_b;
  logic [DATA_W-1:0] da, db;
  logic              take_left;
  logic [SW-1:0]     mid_sum, hi_sum;
  logic [CW-1:0]     mid_min;
  logic [WW-1:0]     w_dbl;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign has_room = (fill_q != CW'(DEPTH));

  assign da = src_q ? ra_b : ra_a;
  assign db = src_q ? rb_b : rb_a;

  // The left run wins on equal values, which keeps the sort stable.
  assign take_left = (i_q < mid_q) &&
                     ((j_q >= hi_q) || ($signed(da) <= $signed(db)));

  // Run bounds for the merge that starts at lo, clipped to the set size.
  assign mid_sum = SW'(lo_q) + SW'(w_q);
  assign mid_min = (mid_sum > SW'(n_q)) ? n_q : mid_sum[CW-1:0];
  assign hi_sum  = SW'(mid_min) + SW'(w_q);
  assign w_dbl   = {w_q[WW-2:0], 1'b0};

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    n_d     = n_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    e_d     = e_q;
    src_d   = src_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            fill_d = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            n_d   = has_room ? fill_q + CW'(1) : fill_q;
            w_d   = WW'(1);
            lo_d  = '0;
            k_d   = '0;
            e_d   = '0;
            src_d = 1'b0;
            if (has_room && (fill_q == '0)) begin
              state_d = ST_ERD;
            end else begin
              state_d = ST_MSET;
            end
          end
        end
      end
      ST_MSET: begin
        i_d     = lo_q;
        mid_d   = mid_min;
        j_d     = mid_min;
        hi_d    = (hi_sum > SW'(n_q)) ? n_q : hi_sum[CW-1:0];
        state_d = ST_MRD;
      end
      ST_MRD: begin
        state_d = ST_MCMP;
      end
      ST_MCMP: begin
        if (take_left) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
        k_d = k_q + CW'(1);
        if ((k_q + CW'(1)) == hi_q) begin
          if (hi_q == n_q) begin
            // Pass complete: the other buffer now holds runs of twice the width.
            w_d   = w_dbl;
            src_d = ~src_q;
            k_d   = '0;
            lo_d  = '0;
            if (w_dbl >= WW'(n_q)) begin
              state_d = ST_ERD;
            end else begin
              state_d = ST_MSET;
            end
          end else begin
            lo_d    = hi_q;
            state_d = ST_MSET;
          end
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_ERD: begin
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_acc) begin
          if ((e_q + CW'(1)) == n_q) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            e_d     = e_q + CW'(1);
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      n_q     <= '0;
      w_q     <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      e_q     <= '0;
      src_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      n_q     <= n_d;
      w_q     <= w_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      e_q     <= e_d;
      src_q   <= src_d;
    end
  end

  // Loads always land in RAM A; a merge writes the buffer it is not reading.
  assign we_a    = (in_acc && has_room) || ((state_q == ST_MCMP) && src_q);
  assign we_b    = (state_q == ST_MCMP) && !src_q;
  assign waddr   = (state_q == ST_LOAD) ? fill_q[AW-1:0] : k_q[AW-1:0];
  assign wdata   = (state_q == ST_LOAD) ? s_axis_tdata : (take_left ? da : db);
  assign raddr_a = ((state_q == ST_ERD) || (state_q == ST_EOUT)) ? e_q[AW-1:0]
                                                                 : i_q[AW-1:0];
  assign raddr_b = j_q[AW-1:0];

  mrgs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (we_a),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ra_a),
    .rdata_b_o (rb_a)
  );

  mrgs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (we_b),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ra_b),
    .rdata_b_o (rb_b)
  );

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_EOUT);
  assign m_axis_tdata  = da;
  assign m_axis_tlast  = ((e_q + CW'(1)) == n_q);
  assign m_axis_tuser  = ovf_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("fill count beyond capacity");

  a_merge_has_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MCMP) |-> ((i_q < mid_q) || (j_q < hi_q)))
    else $error("merge step with both runs exhausted");

  a_write_in_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MRD) || (state_q == ST_MCMP)) |-> (k_q < n_q))
    else $error("merge write index beyond set size");

  a_emit_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (n_q != '0) && (e_q < n_q))
    else $error("result emitted outside the stored set");

endmodule
